### rtl/core/iss_pkg.sv
// Shared types and constants of the 3x3 sharpen block.
package iss_pkg;

   localparam int PIX_W = 8;
   localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   localparam int WIDTH_REG_W = 12;
   localparam int HEIGHT_W    = 12;
   localparam int CHAN_REG_W  = 3;

   localparam int IMAGE_WIDTH_RESET   = 640;
   localparam int IMAGE_HEIGHT_RESET  = 480;
   localparam int CHANNEL_COUNT_RESET = 3;

   // tallest image the row counter covers
   localparam int HEIGHT_LIMIT = 2048;
   localparam int ROW_W        = 11;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_CHANNEL_COUNT = 2'd2
   } csr_reg_type;

endpackage

### rtl/core/iss_req_if.sv
// Input sample channel: valid, ready and one sample.
interface iss_req_if;
   logic                       valid;
   logic                       ready;
   logic [iss_pkg::PIX_W-1:0]  sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

### rtl/core/iss_rsp_if.sv
// Result channel: valid, ready, sharpened sample and framing flags.
interface iss_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [iss_pkg::PIX_W-1:0]  sample_out;
   logic                       last_of_run;
   logic                       end_of_image;

   modport source (output valid, output sample_out, output last_of_run,
                   output end_of_image, input ready);
   modport sink   (input valid, input sample_out, input last_of_run,
                   input end_of_image, output ready);
endinterface

### rtl/core/iss_line_ram.sv
// Line buffer memory: one write port, one read port, registered read data.
module iss_line_ram #(
   parameter int DEPTH = 8192,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [iss_pkg::PIX_W-1:0]  wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [iss_pkg::PIX_W-1:0]  rd_data
);
   import iss_pkg::*;

   logic [PIX_W-1:0] line_mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   // read returns the old contents when both ports hit the same entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/image_sharpen_3x3.sv
// Top level of the streaming 3x3 sharpen block with its two line buffers.
//
//  port group   | direction | handshake    | payload
//  -------------+-----------+--------------+------------------------------------------
//  req_stream   | in        | valid/ready  | sample_in
//  rsp_stream   | out       | valid/ready  | sample_out, last_of_run, end_of_image
//  csr_*        | in        | csr_wen      | csr_index, csr_wdata
//
//  One item is taken per clock while the result port keeps up. First-row items give no
//  result unless that row is the last; other last-row items give two, both out before
//  the next item loads; the rest give one. Reset is synchronous and clears counters,
//  pipeline valids and registers; the line memories are not cleared and need no pass.
//  A stalled result port holds the result register; one more item may still enter
//  the read stage behind it before req_stream.ready drops.
module image_sharpen_3x3 #(
   parameter int MAX_WIDTH    = 2048,
   parameter int MAX_CHANNELS = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   iss_req_if.sink                          req_stream,
   iss_rsp_if.source                        rsp_stream,
   input  logic                             csr_wen,
   input  logic [iss_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [iss_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import iss_pkg::*;

   localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
   localparam int ADDR_W     = $clog2(LINE_DEPTH);
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int WVAL_W     = $clog2(MAX_WIDTH + 1);
   localparam int WCMP_W     = (WVAL_W > WIDTH_REG_W) ? WVAL_W : WIDTH_REG_W;
   localparam int CHI_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CHV_W      = $clog2(MAX_CHANNELS + 1);
   localparam int W_RESET    = (IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                               : IMAGE_WIDTH_RESET;
   localparam int CH_RESET   = (CHANNEL_COUNT_RESET > MAX_CHANNELS) ? MAX_CHANNELS
                                                                    : CHANNEL_COUNT_RESET;
   localparam int ACC_W      = PIX_W + 4;

   // control that travels with an item from the memory read to the arithmetic
   typedef struct packed {
      logic [PIX_W-1:0] sample;
      logic             swap;
      logic [CHI_W-1:0] chan;
      logic             col_one;
      logic             interior;
      logic             emit_main;
      logic             emit_zero;
      logic             final_item;
   } s1_type;

   // ---------------------------------------------------------------- configuration
   logic [WVAL_W-1:0]   width_ff,  width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [CHV_W-1:0]    chans_ff,  chans_in;
   logic                csr_restart;

   logic [WCMP_W-1:0]     width_raw;
   logic [HEIGHT_W-1:0]   height_raw;
   logic [CHAN_REG_W-1:0] chans_raw;

   // saturate register values as they are written
   always_comb begin
      width_raw  = WCMP_W'(csr_wdata[WIDTH_REG_W-1:0]);
      height_raw = csr_wdata[HEIGHT_W-1:0];
      chans_raw  = csr_wdata[CHAN_REG_W-1:0];
      width_in   = width_ff;
      height_in  = height_ff;
      chans_in   = chans_ff;
      csr_restart = 1'b0;
      if (csr_wen) begin
         unique case (csr_reg_type'(csr_index))
            CSR_IMAGE_WIDTH: begin
               csr_restart = 1'b1;
               if (width_raw == '0) begin
                  width_in = WVAL_W'(1);
               end else if (width_raw > WCMP_W'(MAX_WIDTH)) begin
                  width_in = WVAL_W'(MAX_WIDTH);
               end else begin
                  width_in = WVAL_W'(width_raw);
               end
            end
            CSR_IMAGE_HEIGHT: begin
               csr_restart = 1'b1;
               if (height_raw == '0) begin
                  height_in = HEIGHT_W'(1);
               end else if (height_raw > HEIGHT_W'(HEIGHT_LIMIT)) begin
                  height_in = HEIGHT_W'(HEIGHT_LIMIT);
               end else begin
                  height_in = height_raw;
               end
            end
            CSR_CHANNEL_COUNT: begin
               csr_restart = 1'b1;
               if (chans_raw == '0) begin
                  chans_in = CHV_W'(1);
               end else if (chans_raw > CHAN_REG_W'(MAX_CHANNELS)) begin
                  chans_in = CHV_W'(MAX_CHANNELS);
               end else begin
                  chans_in = CHV_W'(chans_raw);
               end
            end
            default: begin
               csr_restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WVAL_W'(W_RESET);
         height_ff <= HEIGHT_W'(IMAGE_HEIGHT_RESET);
         chans_ff  <= CHV_W'(CH_RESET);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         chans_ff  <= chans_in;
      end
   end

   // ---------------------------------------------------------------- raster position
   logic [ROW_W-1:0]  row_ff,  row_in;
   logic [COL_W-1:0]  col_ff,  col_in;
   logic [CHI_W-1:0]  chan_ff, chan_in;
   logic [ADDR_W-1:0] idx_ff,  idx_in;
   logic              swap_ff, swap_in;

   logic req_go;
   logic col_last, chan_last, row_last;

   assign req_go    = req_stream.valid && req_stream.ready;
   assign col_last  = (WVAL_W'(col_ff) == (width_ff - WVAL_W'(1)));
   assign chan_last = (CHV_W'(chan_ff) == (chans_ff - CHV_W'(1)));
   assign row_last  = (HEIGHT_W'(row_ff) == (height_ff - HEIGHT_W'(1)));

   // advance channel, then column, then row; swap line roles at each row end
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      chan_in = chan_ff;
      idx_in  = idx_ff;
      swap_in = swap_ff;
      if (csr_restart) begin
         row_in  = '0;
         col_in  = '0;
         chan_in = '0;
         idx_in  = '0;
         swap_in = 1'b0;
      end else if (req_go) begin
         idx_in = ADDR_W'(idx_ff + ADDR_W'(1));
         if (chan_last) begin
            chan_in = '0;
            if (col_last) begin
               col_in  = '0;
               idx_in  = '0;
               swap_in = !swap_ff;
               row_in  = row_last ? '0 : ROW_W'(row_ff + ROW_W'(1));
            end else begin
               col_in = COL_W'(col_ff + COL_W'(1));
            end
         end else begin
            chan_in = CHI_W'(chan_ff + CHI_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         chan_ff <= '0;
         idx_ff  <= '0;
         swap_ff <= 1'b0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         chan_ff <= chan_in;
         idx_ff  <= idx_in;
         swap_ff <= swap_in;
      end
   end

   // ---------------------------------------------------------------- line memories
   // The line two rows up is read and overwritten at the item's own entry; the line
   // one row up is read one pixel ahead (east), and delay lines recover centre and west.
   logic [ADDR_W-1:0] ahead_addr;
   logic [PIX_W-1:0]  rd0_data, rd1_data;

   assign ahead_addr = ADDR_W'(idx_ff + ADDR_W'(chans_ff));

   iss_line_ram #(.DEPTH(LINE_DEPTH)) u_older_line (
      .clock   (clock),
      .wr_en   (req_go && !swap_ff),
      .wr_addr (idx_ff),
      .wr_data (req_stream.sample_in),
      .rd_en   (req_go),
      .rd_addr (swap_ff ? ahead_addr : idx_ff),
      .rd_data (rd0_data)
   );

   iss_line_ram #(.DEPTH(LINE_DEPTH)) u_newer_line (
      .clock   (clock),
      .wr_en   (req_go && swap_ff),
      .wr_addr (idx_ff),
      .wr_data (req_stream.sample_in),
      .rd_en   (req_go),
      .rd_addr (swap_ff ? idx_ff : ahead_addr),
      .rd_data (rd1_data)
   );

   // First-column samples of the last two rows, one set per line role; the delay
   // lines never see column zero of the row above, so the west of column one
   // comes from here.
   logic [PIX_W-1:0] col0_ff [2][MAX_CHANNELS];

   always_ff @(posedge clock) begin
      if (req_go && (col_ff == '0)) begin
         col0_ff[swap_ff][chan_ff] <= req_stream.sample_in;
      end
   end

   // ---------------------------------------------------------------- read stage
   logic   s1_valid_ff;
   s1_type s1_ff, s1_in;
   logic   s1_adv;

   always_comb begin
      s1_in.sample     = req_stream.sample_in;
      s1_in.swap       = swap_ff;
      s1_in.chan       = chan_ff;
      s1_in.col_one    = (col_ff == COL_W'(1));
      s1_in.interior   = (row_ff > ROW_W'(1)) && (col_ff != '0) && !col_last;
      s1_in.emit_main  = (row_ff != '0);
      s1_in.emit_zero  = row_last;
      s1_in.final_item = row_last && col_last && chan_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_go) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
      if (req_go) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------------------------------------------------------- arithmetic
   logic [PIX_W-1:0] east, north, centre, west;
   logic [PIX_W-1:0] dly_c_ff [MAX_CHANNELS];
   logic [PIX_W-1:0] dly_w_ff [MAX_CHANNELS];

   assign east   = s1_ff.swap ? rd0_data : rd1_data;
   assign north  = s1_ff.swap ? rd1_data : rd0_data;
   assign centre = dly_c_ff[0];
   assign west   = s1_ff.col_one ? col0_ff[!s1_ff.swap][s1_ff.chan] : dly_w_ff[0];

   // Variable-length delay lines: insert at tap chans-1, read at tap 0, so each
   // gives exactly chans items of delay; chained they give twice that.
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            if (i == int'(chans_ff) - 1) begin
               dly_c_ff[i] <= east;
               dly_w_ff[i] <= dly_c_ff[0];
            end else if (i < MAX_CHANNELS - 1) begin
               dly_c_ff[i] <= dly_c_ff[i+1];
               dly_w_ff[i] <= dly_w_ff[i+1];
            end
         end
      end
   end

   logic [PIX_W+2:0]        centre_x5;
   logic [PIX_W+1:0]        ring_sum;
   logic signed [ACC_W-1:0] acc;
   logic [PIX_W-1:0]        sharp;

   always_comb begin
      centre_x5 = {1'b0, centre, 2'b00} + {3'b000, centre};
      ring_sum  = {2'b00, north} + {2'b00, s1_ff.sample} + {2'b00, west} + {2'b00, east};
      acc       = $signed(ACC_W'(centre_x5)) - $signed(ACC_W'(ring_sum));
      // saturate to the pixel range, zero on the border
      if (!s1_ff.interior || (acc < 0)) begin
         sharp = '0;
      end else if (acc > $signed(ACC_W'(PIX_MAX))) begin
         sharp = PIX_MAX;
      end else begin
         sharp = acc[PIX_W-1:0];
      end
   end

   // ---------------------------------------------------------------- result register
   logic             s2_valid_ff;
   logic             s2_main_ff, s2_zero_ff, s2_final_ff;
   logic [PIX_W-1:0] s2_value_ff;
   logic             s2_single, rsp_go, s2_free;

   assign s2_single = !(s2_main_ff && s2_zero_ff);
   assign rsp_go    = rsp_stream.valid && rsp_stream.ready;
   assign s2_free   = !s2_valid_ff || (rsp_go && s2_single);
   assign s1_adv    = s1_valid_ff && s2_free;

   assign req_stream.ready = !s1_valid_ff || s1_adv;

   // load a new item's results, or drop the one just taken
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s2_valid_ff <= s1_ff.emit_main || s1_ff.emit_zero;
      end else if (rsp_go && s2_single) begin
         s2_valid_ff <= 1'b0;
      end
      if (s1_adv) begin
         s2_main_ff  <= s1_ff.emit_main;
         s2_zero_ff  <= s1_ff.emit_zero;
         s2_value_ff <= sharp;
         s2_final_ff <= s1_ff.final_item;
      end else if (rsp_go && !s2_single) begin
         s2_main_ff <= 1'b0;
      end
   end

   assign rsp_stream.valid        = s2_valid_ff;
   assign rsp_stream.sample_out   = s2_main_ff ? s2_value_ff : '0;
   assign rsp_stream.last_of_run  = s2_single;
   assign rsp_stream.end_of_image = s2_single && s2_final_ff;

`ifndef SYNTHESIS
   a_accept_fills_read_stage: assert property (@(posedge clock) disable iff (reset)
      req_go |=> s1_valid_ff)
      else $error("accepted item did not reach the read stage");

   a_column_in_range: assert property (@(posedge clock) disable iff (reset)
      WVAL_W'(col_ff) < width_ff)
      else $error("column counter beyond image width");

   a_channel_in_range: assert property (@(posedge clock) disable iff (reset)
      CHV_W'(chan_ff) < chans_ff)
      else $error("channel index beyond channel count");

   a_end_marks_last: assert property (@(posedge clock) disable iff (reset)
      rsp_stream.valid && rsp_stream.end_of_image |-> rsp_stream.last_of_run)
      else $error("end of image on a result that is not last of its run");

   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_go && !rsp_stream.last_of_run |=> rsp_stream.valid)
      else $error("second result of an item went missing");
`endif

endmodule

### verif/image_sharpen_3x3_checker.sv
`timescale 1ns / 1ps
// Monitor, predictor and scoreboard for the 3x3 sharpen block.
module image_sharpen_3x3_checker #(
   parameter int MAX_WIDTH    = 2048,
   parameter int MAX_CHANNELS = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   iss_req_if                               req_mon,
   iss_rsp_if                               rsp_mon,
   input  logic                             csr_wen,
   input  logic [iss_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [iss_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                               mismatch_count,
   output int                               pending_results,
   output int                               results_checked
);
   import iss_pkg::*;

   localparam int LINE_DEPTH     = MAX_WIDTH * MAX_CHANNELS;
   localparam int MISMATCH_SHOWN = 10;

   typedef struct packed {
      logic [PIX_W-1:0] sample_out;
      logic             last_of_run;
      logic             end_of_image;
   } sharp_result_type;

   sharp_result_type sharpened_q[$];

   // two row stores; swap_sel picks the one holding the row two above
   logic [PIX_W-1:0]       line_mem [2][LINE_DEPTH];
   logic [WIDTH_REG_W-1:0] width_reg;
   logic [HEIGHT_W-1:0]    height_reg;
   logic [CHAN_REG_W-1:0]  chan_reg;
   int unsigned            row_pos;
   int unsigned            col_pos;
   int unsigned            chan_pos;
   bit                     swap_sel;

   function automatic int unsigned bound_reg(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void restart_image();
      row_pos  = 0;
      col_pos  = 0;
      chan_pos = 0;
      swap_sel = 1'b0;
   endfunction

   // Queue the results that one accepted sample releases.
   function automatic void sharpen_sample(logic [PIX_W-1:0] s);
      int unsigned      w;
      int unsigned      h;
      int unsigned      ch;
      int unsigned      idx;
      int               acc;
      int               made;
      bit               last_pix;
      sharp_result_type res;

      w  = bound_reg(width_reg, MAX_WIDTH);
      h  = bound_reg(height_reg, HEIGHT_LIMIT);
      ch = bound_reg(chan_reg, MAX_CHANNELS);
      made = 0;
      if (row_pos >= h || col_pos >= w || chan_pos >= ch) restart_image();
      idx = col_pos * ch + chan_pos;
      if (idx >= LINE_DEPTH) idx = LINE_DEPTH - 1;
      last_pix = (row_pos == h - 1) && (col_pos == w - 1) && (chan_pos == ch - 1);

      if (row_pos >= 1) begin
         res = '0;
         if (row_pos >= 2 && col_pos >= 1 && col_pos + 1 < w) begin
            acc = 5 * int'(line_mem[!swap_sel][idx])
                - int'(line_mem[swap_sel][idx])
                - int'(s)
                - int'(line_mem[!swap_sel][idx - ch])
                - int'(line_mem[!swap_sel][idx + ch]);
            if (acc < 0) acc = 0;
            if (acc > int'(PIX_MAX)) acc = int'(PIX_MAX);
            res.sample_out = acc[PIX_W-1:0];
         end
         sharpened_q.push_back(res);
         made++;
      end

      line_mem[swap_sel][idx] = s;

      if (row_pos == h - 1) begin
         sharpened_q.push_back('0);
         made++;
      end

      if (made > 0) begin
         sharpened_q[sharpened_q.size()-1].last_of_run  = 1'b1;
         sharpened_q[sharpened_q.size()-1].end_of_image = last_pix;
      end

      chan_pos++;
      if (chan_pos >= ch) begin
         chan_pos = 0;
         col_pos++;
         if (col_pos >= w) begin
            col_pos  = 0;
            swap_sel = !swap_sel;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
         end
      end
   endfunction

   always @(posedge clock) begin
      sharp_result_type want;

      if (reset) begin
         width_reg  = WIDTH_REG_W'(IMAGE_WIDTH_RESET);
         height_reg = HEIGHT_W'(IMAGE_HEIGHT_RESET);
         chan_reg   = CHAN_REG_W'(CHANNEL_COUNT_RESET);
         restart_image();
         sharpened_q.delete();
         mismatch_count  = 0;
         results_checked = 0;
      end else begin
         // compare before predicting, so a result never meets its own item
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (sharpened_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MISMATCH_SHOWN)
                  $display("%0t: unexpected result out=%0d last=%0b eoi=%0b", $realtime,
                           rsp_mon.sample_out, rsp_mon.last_of_run, rsp_mon.end_of_image);
            end else begin
               want = sharpened_q.pop_front();
               results_checked++;
               if (rsp_mon.sample_out !== want.sample_out ||
                   rsp_mon.last_of_run !== want.last_of_run ||
                   rsp_mon.end_of_image !== want.end_of_image) begin
                  mismatch_count++;
                  if (mismatch_count <= MISMATCH_SHOWN)
                     $display("%0t: expected %0d last %0b eoi %0b, got %0d last %0b eoi %0b",
                              $realtime, want.sample_out, want.last_of_run, want.end_of_image,
                              rsp_mon.sample_out, rsp_mon.last_of_run, rsp_mon.end_of_image);
               end
            end
         end

         if (csr_wen) begin
            case (csr_index)
               CSR_IMAGE_WIDTH: begin
                  width_reg = csr_wdata[WIDTH_REG_W-1:0];
                  restart_image();
               end
               CSR_IMAGE_HEIGHT: begin
                  height_reg = csr_wdata[HEIGHT_W-1:0];
                  restart_image();
               end
               CSR_CHANNEL_COUNT: begin
                  chan_reg = csr_wdata[CHAN_REG_W-1:0];
                  restart_image();
               end
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready) sharpen_sample(req_mon.sample_in);
      end
      pending_results = sharpened_q.size();
   end

endmodule

### verif/image_sharpen_3x3_tb.sv
`timescale 1ns / 1ps
// Stimulus, flow control and verdict for the 3x3 sharpen block regression.
module image_sharpen_3x3_tb;
   import iss_pkg::*;

   localparam int CLK_PERIOD   = 8;
   localparam int RESET_CYCLES = 4;
   localparam int MAX_WIDTH    = 2048;
   localparam int MAX_CHANNELS = 4;
   localparam int MAX_GAP      = 12;
   // items still in the read stage pass to the result register; leave a comfortable margin
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 20;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_ITEMS  = 110;
   localparam int PHASE_CAP     = 60;
   localparam int CYCLE_LIMIT   = 400000;
   // the one register index the block leaves unused
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum int {FILL_UNIFORM, FILL_EXTREME, FILL_SMOOTH} fill_style_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wen;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   rsp_take     = 1'b0;
   logic                   rsp_hold     = 1'b0;
   bit                     hold_trigger = 1'b0;
   bit                     send_calm    = 1'b0;
   int                     smooth_level = 128;
   int                     mismatch_count;
   int                     pending_results;
   int                     results_checked;
   int                     samples_sent   = 0;
   int                     settings_used  = 0;
   int unsigned            cycle_count    = 0;

   // a small image whose interior hits both saturation limits
   logic [PIX_W-1:0] peak_image [16] = '{
      8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'hFF, 8'h00, 8'h00,
      8'h00, 8'h00, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF
   };
   logic [PIX_W-1:0] first_row_probe [6] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0};

   iss_req_if req_if ();
   iss_rsp_if rsp_if ();

   // the long stall overrides whatever the receiver would otherwise do
   assign rsp_if.ready = rsp_take && !rsp_hold;

   image_sharpen_3x3 #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_if),
      .rsp_stream (rsp_if),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   image_sharpen_3x3_checker #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results),
      .results_checked (results_checked)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Watchdog: give up well beyond the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("image_sharpen_3x3 regression: fail");
         $finish;
      end
   end

   // Receiver: draw a wait before each item, with calm stretches now and then.
   initial begin : result_taker
      int gap;
      int taken;
      bit take_calm;

      taken     = 0;
      take_calm = 1'b0;
      @(posedge clock);
      forever begin
         if (taken % 40 == 0) take_calm = ($urandom_range(0, 3) == 0);
         gap = take_calm ? 0 : $urandom_range(0, MAX_GAP);
         if (gap != 0) begin
            rsp_take <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_take <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         taken++;
      end
   end

   // Long receiver stall, counted here so that the sender keeps pushing meanwhile.
   initial begin : result_stall
      wait (hold_trigger);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   function automatic logic [PIX_W-1:0] pick_value(fill_style_type style);
      int v;
      case (style)
         FILL_EXTREME: v = $urandom_range(0, 1) ? int'(PIX_MAX) : 0;
         FILL_SMOOTH: begin
            // drift slowly so that the sharpened values land mid-range
            smooth_level += int'($urandom_range(0, 12)) - 6;
            if (smooth_level < 0) smooth_level = 0;
            if (smooth_level > int'(PIX_MAX)) smooth_level = int'(PIX_MAX);
            v = smooth_level;
         end
         default: v = $urandom_range(0, int'(PIX_MAX));
      endcase
      return v[PIX_W-1:0];
   endfunction

   // Offer one item and hold it until the block takes it.
   task automatic send_sample(input logic [PIX_W-1:0] value);
      int gap;
      gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.sample_in <= value;
      do @(posedge clock); while (!req_if.ready);
      samples_sent++;
   endtask

   // Drop valid, wait for every expected result, then let in-flight first-row items clear.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three geometry registers back to back, write enable held high.
   task automatic set_geometry(input int unsigned w, input int unsigned h,
                               input int unsigned ch);
      csr_wen   <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= CSR_DATA_W'(w);
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= CSR_DATA_W'(h);
      @(posedge clock);
      csr_index <= CSR_CHANNEL_COUNT;
      csr_wdata <= CSR_DATA_W'(ch);
      @(posedge clock);
      csr_wen <= 1'b0;
      settings_used++;
   endtask

   task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned ch,
                            input int count, input fill_style_type style);
      wait_idle();
      set_geometry(w, h, ch);
      repeat (count) send_sample(pick_value(style));
   endtask

   initial begin : stimulus
      int             n;
      int             random_sent;
      int unsigned    w;
      int unsigned    h;
      int unsigned    ch;
      int unsigned    image_items;
      fill_style_type style;

      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.sample_in <= '0;
      csr_wen          <= 1'b0;
      csr_index        <= CSR_IMAGE_WIDTH;
      csr_wdata        <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset geometry: a handful of first-row items, which must release nothing.
      foreach (first_row_probe[i]) send_sample(first_row_probe[i]);

      // One 4x4 single-channel image with both saturation limits in its interior.
      wait_idle();
      set_geometry(4, 4, 1);
      foreach (peak_image[i]) send_sample(peak_image[i]);

      // Back-pressure: stall the receiver for a long stretch while items keep coming.
      wait_idle();
      set_geometry(6, 5, 2);
      send_calm    = 1'b1;
      hold_trigger = 1'b1;
      repeat (120) send_sample(pick_value(FILL_UNIFORM));
      send_calm = 1'b0;

      // Register extremes: oversize and zero values saturate, tiny widths give zeros.
      run_phase(4095, 1, 7, 40, FILL_UNIFORM);
      run_phase(2048, 4095, 4, 30, FILL_EXTREME);
      run_phase(1, 2048, 0, 40, FILL_UNIFORM);
      run_phase(0, 0, 1, 20, FILL_UNIFORM);
      run_phase(2, 3, 3, 40, FILL_SMOOTH);
      run_phase(3, 3, 1, 18, FILL_EXTREME);

      // Part of an image, a write to the unused index, then carry on without restart.
      run_phase(5, 4, 2, 17, FILL_SMOOTH);
      wait_idle();
      csr_wen   <= 1'b1;
      csr_index <= CSR_SPARE;
      csr_wdata <= CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_wen <= 1'b0;
      repeat (40) send_sample(pick_value(FILL_SMOOTH));

      // Random phases: mostly small geometries, whole and partial images.
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         w  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
         h  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
         ch = $urandom_range(0, 7);
         image_items = (w == 0 ? 1 : w) * (h == 0 ? 1 : h) *
                       (ch == 0 ? 1 : (ch > MAX_CHANNELS ? MAX_CHANNELS : ch));
         n = image_items * $urandom_range(1, 2) + $urandom_range(0, image_items / 2);
         if (n > PHASE_CAP) n = PHASE_CAP;
         case ($urandom_range(0, 2))
            0:       style = FILL_EXTREME;
            1:       style = FILL_SMOOTH;
            default: style = FILL_UNIFORM;
         endcase
         send_calm = ($urandom_range(0, 3) == 0);
         run_phase(w, h, ch, n, style);
         random_sent += n;
      end

      // Drain, then give any stray result time to show up.
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d samples across %0d register settings; %0d results checked.",
               samples_sent, settings_used, results_checked);
      $display("Included a %0d-cycle result stall and both register saturation limits.",
               HOLD_CYCLES);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("image_sharpen_3x3 regression: pass");
      end else begin
         $display("image_sharpen_3x3 regression: fail");
      end
      $finish;
   end

endmodule

### image_sharpen_3x3.f
rtl/core/iss_pkg.sv
rtl/core/iss_req_if.sv
rtl/core/iss_rsp_if.sv
rtl/core/iss_line_ram.sv
rtl/core/image_sharpen_3x3.sv
verif/image_sharpen_3x3_checker.sv
verif/image_sharpen_3x3_tb.sv
